FILE: src/tlnt_pkg.sv
// Shared types, sizes, codes and helpers for the two-level name table.
package tlnt_pkg;

    localparam int MAX_GROUPS  = 8;
    localparam int MAX_ENTRIES = 8;

    localparam int KEY_W     = 64;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int IDX_OUT_W = 3;

    localparam int GIDX_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int EIDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int GCNT_W  = $clog2(MAX_GROUPS + 1);
    localparam int ECNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int EDEPTH  = MAX_GROUPS * MAX_ENTRIES;
    localparam int EADDR_W = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;

    typedef logic [KEY_W-1:0]     t_key;
    typedef logic [OP_W-1:0]      t_op;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [IDX_OUT_W-1:0] t_idx_out;
    typedef logic [GIDX_W-1:0]    t_gidx;
    typedef logic [EIDX_W-1:0]    t_eidx;
    typedef logic [GCNT_W-1:0]    t_gcnt;
    typedef logic [ECNT_W-1:0]    t_ecnt;
    typedef logic [EADDR_W-1:0]   t_eaddr;

    localparam t_op OP_ADD_GROUP    = 2'd0;
    localparam t_op OP_ADD_ENTRY    = 2'd1;
    localparam t_op OP_REMOVE_ENTRY = 2'd2;
    localparam t_op OP_SEARCH_ENTRY = 2'd3;

    localparam t_status STS_OK       = 2'd0;
    localparam t_status STS_NO_GROUP = 2'd1;
    localparam t_status STS_NO_ENTRY = 2'd2;
    localparam t_status STS_FULL     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GSCAN,
        ST_ESCAN,
        ST_MOVE,
        ST_DONE
    } t_state;

    // Flat address of one entry slot: each group owns MAX_ENTRIES slots.
    function automatic t_eaddr entry_addr(input t_gidx g, input t_eidx e);
        entry_addr = EADDR_W'(g) * EADDR_W'(MAX_ENTRIES) + EADDR_W'(e);
    endfunction

endpackage

FILE: src/two_level_name_table.sv
// Two-level keyed name table: groups of entries, searched with one shared key comparator.
//
//   channel   direction  handshake                  payload
//   command   in         i_in_valid / o_in_ready    i_operation, i_group_key, i_entry_key
//   response  out        o_out_valid / i_out_ready  o_status, o_group_index, o_entry_index
//
// Add group offers its response in the cycle after acceptance.
// Other operations compare one key per cycle: up to 8 group keys, then up to 9 entry
// steps (8 keys and the end of the list) or 8 keys plus the slot move of a remove.
// Reset clears the state machine and the group count; key stores need no clearing.
// One item is in flight at a time; a stalled response holds the block out of idle.
module two_level_name_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  tlnt_pkg::t_op             i_operation,
    input  tlnt_pkg::t_key            i_group_key,
    input  tlnt_pkg::t_key            i_entry_key,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output tlnt_pkg::t_status         o_status,
    output tlnt_pkg::t_idx_out        o_group_index,
    output tlnt_pkg::t_idx_out        o_entry_index
);

    tlnt_pkg::t_state   r_state, n_state;
    tlnt_pkg::t_gcnt    r_group_count, n_group_count;
    tlnt_pkg::t_gcnt    r_gidx, n_gidx;
    tlnt_pkg::t_ecnt    r_eidx, n_eidx;
    tlnt_pkg::t_gidx    r_gsel, n_gsel;
    tlnt_pkg::t_eidx    r_hole, n_hole;
    tlnt_pkg::t_op      r_op, n_op;
    tlnt_pkg::t_key     r_gkey, n_gkey;
    tlnt_pkg::t_key     r_ekey, n_ekey;
    tlnt_pkg::t_status  r_status, n_status;
    tlnt_pkg::t_idx_out r_gi, n_gi;
    tlnt_pkg::t_idx_out r_ei, n_ei;

    tlnt_pkg::t_ecnt    r_entry_cnt [tlnt_pkg::MAX_GROUPS];

    logic               g_we;
    tlnt_pkg::t_gidx    g_waddr;
    tlnt_pkg::t_key     g_wdata;
    tlnt_pkg::t_key     g_rdata;
    logic               e_we;
    tlnt_pkg::t_eaddr   e_waddr;
    tlnt_pkg::t_key     e_wdata;
    tlnt_pkg::t_key     e_rdata;
    logic               cnt_we;
    tlnt_pkg::t_gidx    cnt_waddr;
    tlnt_pkg::t_ecnt    cnt_wdata;

    tlnt_pkg::t_gidx    g_cur;
    tlnt_pkg::t_gidx    cnt_sel;
    tlnt_pkg::t_ecnt    cnt_rd;
    tlnt_pkg::t_key     cmp_a, cmp_b;
    logic               key_match;

    tlnt_ram #(
        .WIDTH (tlnt_pkg::KEY_W),
        .DEPTH (tlnt_pkg::MAX_GROUPS)
    ) u_group_keys (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (n_gidx[tlnt_pkg::GIDX_W-1:0]),
        .o_rdata (g_rdata)
    );

    tlnt_ram #(
        .WIDTH (tlnt_pkg::KEY_W),
        .DEPTH (tlnt_pkg::EDEPTH)
    ) u_entry_keys (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (tlnt_pkg::entry_addr(n_gsel, n_eidx[tlnt_pkg::EIDX_W-1:0])),
        .o_rdata (e_rdata)
    );

    assign g_cur   = r_gidx[tlnt_pkg::GIDX_W-1:0];
    assign cnt_sel = (r_state == tlnt_pkg::ST_GSCAN) ? g_cur : r_gsel;
    assign cnt_rd  = r_entry_cnt[cnt_sel];

    // The one comparator serves both the group walk and the entry walk.
    assign cmp_a     = (r_state == tlnt_pkg::ST_GSCAN) ? g_rdata : e_rdata;
    assign cmp_b     = (r_state == tlnt_pkg::ST_GSCAN) ? r_gkey : r_ekey;
    assign key_match = (cmp_a == cmp_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tlnt_pkg::ST_IDLE;
            r_group_count <= '0;
        end else begin
            r_state       <= n_state;
            r_group_count <= n_group_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gidx   <= n_gidx;
        r_eidx   <= n_eidx;
        r_gsel   <= n_gsel;
        r_hole   <= n_hole;
        r_op     <= n_op;
        r_gkey   <= n_gkey;
        r_ekey   <= n_ekey;
        r_status <= n_status;
        r_gi     <= n_gi;
        r_ei     <= n_ei;
        if (cnt_we) begin
            r_entry_cnt[cnt_waddr] <= cnt_wdata;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_group_count = r_group_count;
        n_gidx        = r_gidx;
        n_eidx        = r_eidx;
        n_gsel        = r_gsel;
        n_hole        = r_hole;
        n_op          = r_op;
        n_gkey        = r_gkey;
        n_ekey        = r_ekey;
        n_status      = r_status;
        n_gi          = r_gi;
        n_ei          = r_ei;
        g_we          = 1'b0;
        g_waddr       = r_group_count[tlnt_pkg::GIDX_W-1:0];
        g_wdata       = r_gkey;
        e_we          = 1'b0;
        e_waddr       = tlnt_pkg::entry_addr(r_gsel, r_hole);
        e_wdata       = r_ekey;
        cnt_we        = 1'b0;
        cnt_waddr     = r_gsel;
        cnt_wdata     = '0;

        case (r_state)
            tlnt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_operation;
                    n_gkey   = i_group_key;
                    n_ekey   = i_entry_key;
                    n_gidx   = '0;
                    n_status = tlnt_pkg::STS_OK;
                    n_gi     = '0;
                    n_ei     = '0;
                    n_state  = tlnt_pkg::ST_GSCAN;
                    if (i_operation == tlnt_pkg::OP_ADD_GROUP) begin
                        n_state = tlnt_pkg::ST_DONE;
                        if (r_group_count >= tlnt_pkg::GCNT_W'(tlnt_pkg::MAX_GROUPS)) begin
                            n_status = tlnt_pkg::STS_FULL;
                        end else begin
                            // The key register is loaded this cycle, so write the port value.
                            n_gkey        = i_group_key;
                            g_we          = 1'b1;
                            g_wdata       = i_group_key;
                            cnt_we        = 1'b1;
                            cnt_waddr     = r_group_count[tlnt_pkg::GIDX_W-1:0];
                            cnt_wdata     = '0;
                            n_group_count = r_group_count + 1'b1;
                            n_gi          = tlnt_pkg::t_idx_out'(r_group_count);
                        end
                    end
                end
            end

            tlnt_pkg::ST_GSCAN: begin
                if (r_gidx >= r_group_count) begin
                    n_status = tlnt_pkg::STS_NO_GROUP;
                    n_state  = tlnt_pkg::ST_DONE;
                end else if (key_match) begin
                    n_gsel = g_cur;
                    n_gi   = tlnt_pkg::t_idx_out'(g_cur);
                    if (r_op == tlnt_pkg::OP_ADD_ENTRY) begin
                        n_state = tlnt_pkg::ST_DONE;
                        if (cnt_rd >= tlnt_pkg::ECNT_W'(tlnt_pkg::MAX_ENTRIES)) begin
                            n_status = tlnt_pkg::STS_FULL;
                        end else begin
                            e_we      = 1'b1;
                            e_waddr   = tlnt_pkg::entry_addr(g_cur,
                                            cnt_rd[tlnt_pkg::EIDX_W-1:0]);
                            e_wdata   = r_ekey;
                            cnt_we    = 1'b1;
                            cnt_waddr = g_cur;
                            cnt_wdata = cnt_rd + 1'b1;
                            n_ei      = tlnt_pkg::t_idx_out'(cnt_rd);
                        end
                    end else begin
                        n_eidx  = '0;
                        n_state = tlnt_pkg::ST_ESCAN;
                    end
                end else begin
                    n_gidx = r_gidx + 1'b1;
                end
            end

            tlnt_pkg::ST_ESCAN: begin
                if (r_eidx >= cnt_rd) begin
                    n_status = tlnt_pkg::STS_NO_ENTRY;
                    n_state  = tlnt_pkg::ST_DONE;
                end else if (key_match) begin
                    n_ei = tlnt_pkg::t_idx_out'(r_eidx);
                    if (r_op == tlnt_pkg::OP_REMOVE_ENTRY) begin
                        // Fetch the group's last entry; it fills the hole next cycle.
                        n_hole  = r_eidx[tlnt_pkg::EIDX_W-1:0];
                        n_eidx  = cnt_rd - 1'b1;
                        n_state = tlnt_pkg::ST_MOVE;
                    end else begin
                        n_state = tlnt_pkg::ST_DONE;
                    end
                end else begin
                    n_eidx = r_eidx + 1'b1;
                end
            end

            tlnt_pkg::ST_MOVE: begin
                e_we      = 1'b1;
                e_waddr   = tlnt_pkg::entry_addr(r_gsel, r_hole);
                e_wdata   = e_rdata;
                cnt_we    = 1'b1;
                cnt_waddr = r_gsel;
                cnt_wdata = cnt_rd - 1'b1;
                n_state   = tlnt_pkg::ST_DONE;
            end

            tlnt_pkg::ST_DONE: begin
                if (i_out_ready) begin
                    n_state = tlnt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tlnt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready    = (r_state == tlnt_pkg::ST_IDLE);
    assign o_out_valid   = (r_state == tlnt_pkg::ST_DONE);
    assign o_status      = r_status;
    assign o_group_index = r_gi;
    assign o_entry_index = r_ei;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("command accepted while a response is pending");

    a_group_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_group_count <= tlnt_pkg::GCNT_W'(tlnt_pkg::MAX_GROUPS))
        else $error("group count beyond table size");

    a_escan_live_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlnt_pkg::ST_ESCAN) |-> (tlnt_pkg::GCNT_W'(r_gsel) < r_group_count))
        else $error("entry walk on a group that does not exist");

    a_gscan_not_add_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlnt_pkg::ST_GSCAN) |-> (r_op != tlnt_pkg::OP_ADD_GROUP))
        else $error("group walk started for an add group");

    a_no_group_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == tlnt_pkg::STS_NO_GROUP)
            |-> (o_group_index == '0 && o_entry_index == '0))
        else $error("missing group reported with a nonzero index");

endmodule

FILE: src/tlnt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tlnt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the two-level name table: randomized commands against a scoreboard.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        tlnt_pkg::t_op  op;
        tlnt_pkg::t_key group_key;
        tlnt_pkg::t_key entry_key;
    } t_cmd;

    typedef struct packed {
        tlnt_pkg::t_status  status;
        tlnt_pkg::t_idx_out group_index;
        tlnt_pkg::t_idx_out entry_index;
    } t_rsp;

    localparam int RANDOM_PER_PHASE = 433;
    localparam int POOL_SIZE        = 6;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    t_cmd bus_cmd   = '0;

    logic               o_in_ready;
    logic               o_out_valid;
    tlnt_pkg::t_status  o_status;
    tlnt_pkg::t_idx_out o_group_index;
    tlnt_pkg::t_idx_out o_entry_index;

    two_level_name_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (bus_cmd.op),
        .i_group_key   (bus_cmd.group_key),
        .i_entry_key   (bus_cmd.entry_key),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_status      (o_status),
        .o_group_index (o_group_index),
        .o_entry_index (o_entry_index)
    );

    // Shadow copy of the table contents.
    tlnt_pkg::t_gcnt shadow_groups;
    tlnt_pkg::t_key  shadow_group_key [tlnt_pkg::MAX_GROUPS];
    tlnt_pkg::t_ecnt shadow_entry_cnt [tlnt_pkg::MAX_GROUPS];
    tlnt_pkg::t_key  shadow_entry_key [tlnt_pkg::MAX_GROUPS][tlnt_pkg::MAX_ENTRIES];

    t_cmd cmd_pending[$];
    t_rsp rsp_due[$];

    int pushed_cnt   = 0;
    int sent_cnt     = 0;
    int accepted_cnt = 0;
    int mismatches   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Keys used to build well-formed traffic.
    tlnt_pkg::t_key known_group [tlnt_pkg::MAX_GROUPS];
    tlnt_pkg::t_key entry_pool  [tlnt_pkg::MAX_GROUPS][POOL_SIZE];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic tlnt_pkg::t_key random_key();
        random_key = {$urandom, $urandom};
    endfunction

    // Applies one command to the shadow table and returns the response it should produce.
    function automatic t_rsp apply_command(t_cmd c);
        t_rsp r;
        int   g;
        int   e;
        r = '0;
        r.status = tlnt_pkg::STS_OK;
        if (c.op == tlnt_pkg::OP_ADD_GROUP) begin
            if (shadow_groups >= tlnt_pkg::MAX_GROUPS) begin
                r.status = tlnt_pkg::STS_FULL;
            end else begin
                shadow_group_key[shadow_groups] = c.group_key;
                shadow_entry_cnt[shadow_groups] = '0;
                r.group_index = tlnt_pkg::t_idx_out'(shadow_groups);
                shadow_groups = shadow_groups + 1'b1;
            end
        end else begin
            g = -1;
            for (int i = 0; i < shadow_groups; i++) begin
                if (g < 0 && shadow_group_key[i] == c.group_key) g = i;
            end
            if (g < 0) begin
                r.status = tlnt_pkg::STS_NO_GROUP;
            end else begin
                r.group_index = tlnt_pkg::t_idx_out'(g);
                if (c.op == tlnt_pkg::OP_ADD_ENTRY) begin
                    if (shadow_entry_cnt[g] >= tlnt_pkg::MAX_ENTRIES) begin
                        r.status = tlnt_pkg::STS_FULL;
                    end else begin
                        shadow_entry_key[g][shadow_entry_cnt[g]] = c.entry_key;
                        r.entry_index = tlnt_pkg::t_idx_out'(shadow_entry_cnt[g]);
                        shadow_entry_cnt[g] = shadow_entry_cnt[g] + 1'b1;
                    end
                end else begin
                    e = -1;
                    for (int i = 0; i < shadow_entry_cnt[g]; i++) begin
                        if (e < 0 && shadow_entry_key[g][i] == c.entry_key) e = i;
                    end
                    if (e < 0) begin
                        r.status = tlnt_pkg::STS_NO_ENTRY;
                    end else begin
                        r.entry_index = tlnt_pkg::t_idx_out'(e);
                        if (c.op == tlnt_pkg::OP_REMOVE_ENTRY) begin
                            // The last entry of the group fills the hole.
                            shadow_entry_key[g][e] =
                                shadow_entry_key[g][shadow_entry_cnt[g] - 1];
                            shadow_entry_cnt[g] = shadow_entry_cnt[g] - 1'b1;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic push_cmd(tlnt_pkg::t_op op, tlnt_pkg::t_key gk, tlnt_pkg::t_key ek);
        t_cmd c;
        c.op = op;
        c.group_key = gk;
        c.entry_key = ek;
        cmd_pending.push_back(c);
        pushed_cnt++;
    endtask

    // Sender and receiver, driven away from the sampling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (!in_valid || accepted_cnt == sent_cnt) begin
                if (cmd_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    bus_cmd  <= cmd_pending.pop_front();
                    in_valid <= 1'b1;
                    sent_cnt <= sent_cnt + 1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Prediction on command acceptance, checking on response acceptance.
    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                rsp_due.push_back(apply_command(bus_cmd));
                accepted_cnt = accepted_cnt + 1;
            end
            if (o_out_valid && out_ready) begin
                got.status      = o_status;
                got.group_index = o_group_index;
                got.entry_index = o_entry_index;
                if (rsp_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: status %0d group %0d entry %0d",
                                 got.status, got.group_index, got.entry_index);
                end else begin
                    want = rsp_due.pop_front();
                    if (got.status !== want.status || got.group_index !== want.group_index ||
                        got.entry_index !== want.entry_index) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.status, want.group_index, want.entry_index,
                                     got.status, got.group_index, got.entry_index);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL two_level_name_table");
        $finish;
    end

    initial begin
        int             pick;
        int             g;
        tlnt_pkg::t_op  op;
        tlnt_pkg::t_key gk;
        tlnt_pkg::t_key ek;

        shadow_groups = '0;
        known_group[0] = '0;
        known_group[1] = '1;
        known_group[2] = '0;
        for (int i = 3; i < tlnt_pkg::MAX_GROUPS; i++) known_group[i] = random_key();
        for (int i = 0; i < tlnt_pkg::MAX_GROUPS; i++) begin
            for (int j = 0; j < POOL_SIZE; j++) entry_pool[i][j] = random_key();
        end
        entry_pool[0][0] = '1;
        entry_pool[0][1] = '0;
        entry_pool[1][2] = '1;
        entry_pool[1][3] = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 29 : 0;
            if (phase == 0) begin
                // Lookups in an empty table, then duplicates, hits, misses and removal.
                push_cmd(tlnt_pkg::OP_SEARCH_ENTRY, random_key(), random_key());
                for (int i = 0; i < 3; i++)
                    push_cmd(tlnt_pkg::OP_ADD_GROUP, known_group[i], random_key());
                push_cmd(tlnt_pkg::OP_ADD_ENTRY, known_group[0], '1);
                push_cmd(tlnt_pkg::OP_ADD_ENTRY, known_group[0], '0);
                push_cmd(tlnt_pkg::OP_ADD_ENTRY, known_group[0], '1);
                push_cmd(tlnt_pkg::OP_SEARCH_ENTRY, known_group[0], '1);
                push_cmd(tlnt_pkg::OP_SEARCH_ENTRY, known_group[0], random_key());
                push_cmd(tlnt_pkg::OP_REMOVE_ENTRY, known_group[0], random_key());
                push_cmd(tlnt_pkg::OP_REMOVE_ENTRY, known_group[0], '1);
                push_cmd(tlnt_pkg::OP_REMOVE_ENTRY, known_group[0], '0);
                push_cmd(tlnt_pkg::OP_REMOVE_ENTRY, random_key(), '1);
                push_cmd(tlnt_pkg::OP_ADD_ENTRY, random_key(), random_key());
                // Fill one group past its entry limit.
                for (int k = 0; k <= tlnt_pkg::MAX_ENTRIES; k++)
                    push_cmd(tlnt_pkg::OP_ADD_ENTRY, known_group[1],
                             entry_pool[1][k % POOL_SIZE]);
                // Fill the group table past its limit.
                for (int i = 3; i < tlnt_pkg::MAX_GROUPS; i++)
                    push_cmd(tlnt_pkg::OP_ADD_GROUP, known_group[i], random_key());
                push_cmd(tlnt_pkg::OP_ADD_GROUP, random_key(), random_key());
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                op = (pick < 5)  ? tlnt_pkg::OP_ADD_GROUP :
                     (pick < 40) ? tlnt_pkg::OP_ADD_ENTRY :
                     (pick < 70) ? tlnt_pkg::OP_REMOVE_ENTRY : tlnt_pkg::OP_SEARCH_ENTRY;
                g  = $urandom_range(tlnt_pkg::MAX_GROUPS - 1);
                gk = ($urandom_range(99) < 88) ? known_group[g] : random_key();
                ek = ($urandom_range(99) < 90) ? entry_pool[g][$urandom_range(POOL_SIZE - 1)]
                                               : random_key();
                push_cmd(op, gk, ek);
            end
            // The sender stays quiet until every response of the phase is back.
            while (accepted_cnt != pushed_cnt || rsp_due.size() != 0) @(posedge i_clk);
        end

        repeat (40) @(posedge i_clk);
        if (rsp_due.size() != 0) begin
            mismatches += rsp_due.size();
            $display("%0d responses never arrived", rsp_due.size());
        end
        if (mismatches == 0) begin
            $display("PASS two_level_name_table");
        end else begin
            $display("FAIL two_level_name_table");
        end
        $finish;
    end

endmodule
